// File: rtl/lgs_pkg.sv
package lgs_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int COORD_W    = 8;
    localparam int GRID_RESET = 200;
    localparam int DIM_MIN    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic above;
        logic current;
    } lgs_lines_t;

    // column of the window: [0] top, [1] middle, [2] bottom
    typedef logic [2:0] lgs_col_t;

    function automatic logic [1:0] lgs_pop3(input lgs_col_t v);
        lgs_pop3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
    endfunction

    // B3/S23
    function automatic logic lgs_rule(input logic alive, input logic [3:0] count);
        if (alive)
        begin
            lgs_rule = (count == 4'd2) || (count == 4'd3);
        end
        else
        begin
            lgs_rule = (count == 4'd3);
        end
    endfunction

endpackage

// File: rtl/lgs_line_store.sv
module lgs_line_store
    import lgs_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output lgs_lines_t               rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  lgs_lines_t               wr_data
);

    lgs_lines_t mem [DEPTH];
    lgs_lines_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/life_generation_stencil.sv
// Game of Life (B3/S23) generation stencil.
// Input channel (in_valid/in_stall): one cell per beat in raster order,
// grid_width x grid_height cells, then grid_width+1 more beats to drain.
// Output channel (out_valid/out_stall): next state of each cell in raster
// order with its row/column; last_cell marks the final cell, after which
// the stream restarts at cell (0,0).
// Config channel (cfg_valid/cfg_ready, always ready): index 0 grid_width,
// index 1 grid_height, clamped to 3..MAX. Any write restarts the stream.
// Throughput: one beat per cycle unless stalled. A cell's result follows,
// via the stencil stage and output register, the beat grid_width+1 beats
// behind it. Both line stores share one 2-bit wide RAM with a registered
// read; a beat reads its column on acceptance and writes it back from the
// stencil stage. Reset: dimensions return to 200x200, stream position and
// window clear, RAM contents are not cleared (never used before written).
// When out_stall holds a result, one more beat may be taken into the
// stencil stage; in_stall rises once that stage must emit and cannot.
module life_generation_stencil
    import lgs_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cell_alive,
    input  logic                  flush,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  next_alive,
    output logic [COORD_W-1:0]    cell_row,
    output logic [COORD_W-1:0]    cell_col,
    output logic                  last_cell,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int CLW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int CLH = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
    localparam int XA  = (RW > WW) ? RW : WW;
    localparam int XW  = (XA > COORD_W) ? XA : COORD_W;
    localparam int W_RST = (MAX_WIDTH < GRID_RESET) ? MAX_WIDTH : GRID_RESET;
    localparam int H_RST = (MAX_HEIGHT < GRID_RESET) ? MAX_HEIGHT : GRID_RESET;

    logic [WW-1:0] w_reg, w_next;
    logic [HW-1:0] h_reg, h_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_bottom_reg, s1_top_ok_reg, s1_mid_ok_reg;
    logic              s1_emit_reg, s1_last_reg, s1_left_ok_reg, s1_right_ok_reg;
    logic [CW-1:0]     s1_addr_reg;
    logic [COORD_W-1:0] s1_row_reg, s1_col_reg;

    lgs_col_t win0_reg, win1_reg, win2_reg;
    lgs_col_t win0_next, win1_next, win2_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_alive_reg, out_last_reg;
    logic [COORD_W-1:0] out_row_reg, out_col_reg;

    logic cfg_we, accept, s1_adv, out_free, out_load;
    logic emit0, bottom0, top_ok0, mid_ok0, last0;
    logic [XW-1:0] orow0, ocol0;
    logic [WW-1:0] col_inc;
    logic [CLW-1:0] cfg_w_ext;
    logic [CLH-1:0] cfg_h_ext;
    lgs_lines_t rd_lines, wr_lines;
    lgs_col_t   new_col;
    logic       top1, mid1;
    logic [3:0] count1;
    logic       alive1;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign accept    = in_valid && !in_stall;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || out_free);
    assign out_load = s1_adv && s1_emit_reg;
    assign in_stall = s1_valid_reg && !s1_adv;

    // configuration, clamped on write
    always_comb
    begin
        w_next    = w_reg;
        h_next    = h_reg;
        cfg_w_ext = CLW'(cfg_data);
        cfg_h_ext = CLH'(cfg_data);
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:
                begin
                    if (cfg_w_ext < CLW'(DIM_MIN))
                        w_next = WW'(DIM_MIN);
                    else if (cfg_w_ext > CLW'(MAX_WIDTH))
                        w_next = WW'(MAX_WIDTH);
                    else
                        w_next = WW'(cfg_w_ext);
                end
                REG_GRID_HEIGHT:
                begin
                    if (cfg_h_ext < CLH'(DIM_MIN))
                        h_next = HW'(DIM_MIN);
                    else if (cfg_h_ext > CLH'(MAX_HEIGHT))
                        h_next = HW'(MAX_HEIGHT);
                    else
                        h_next = HW'(cfg_h_ext);
                end
                default:
                begin
                    w_next = w_reg;
                end
            endcase
        end
    end

    // raster position of the incoming beat
    always_comb
    begin
        emit0   = (row_reg >= RW'(2)) || ((row_reg == RW'(1)) && (col_reg != '0));
        bottom0 = !flush && (row_reg < RW'(h_reg)) && cell_alive;
        top_ok0 = row_reg >= RW'(2);
        mid_ok0 = (row_reg != '0) && (row_reg <= RW'(h_reg));
        last0   = (row_reg == RW'(h_reg) + RW'(1)) && (col_reg == '0);
        col_inc = WW'(col_reg) + WW'(1);
        if (col_reg == '0)
        begin
            orow0 = XW'(row_reg) - XW'(2);
            ocol0 = XW'(w_reg) - XW'(1);
        end
        else
        begin
            orow0 = XW'(row_reg) - XW'(1);
            ocol0 = XW'(col_reg) - XW'(1);
        end

        row_next = row_reg;
        col_next = col_reg;
        if (cfg_we)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (last0)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (col_inc >= w_reg)
            begin
                row_next = row_reg + RW'(1);
                col_next = '0;
            end
            else
            begin
                col_next = CW'(col_inc);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cfg_we)
            s1_valid_next = 1'b0;
        else if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    lgs_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_lines),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_lines)
    );

    // stencil stage
    always_comb
    begin
        top1             = s1_top_ok_reg && rd_lines.above;
        mid1             = s1_mid_ok_reg && rd_lines.current;
        new_col          = {s1_bottom_reg, mid1, top1};
        wr_lines.above   = mid1;
        wr_lines.current = s1_bottom_reg;
        count1 = (s1_left_ok_reg ? {2'b00, lgs_pop3(win1_reg)} : 4'd0)
               + (s1_right_ok_reg ? {2'b00, lgs_pop3(new_col)} : 4'd0)
               + {3'b000, win2_reg[0]} + {3'b000, win2_reg[2]};
        alive1 = lgs_rule(win2_reg[1], count1);

        win0_next = win0_reg;
        win1_next = win1_reg;
        win2_next = win2_reg;
        if (cfg_we || (s1_adv && s1_last_reg))
        begin
            win0_next = '0;
            win1_next = '0;
            win2_next = '0;
        end
        else if (s1_adv)
        begin
            win0_next = win1_reg;
            win1_next = win2_reg;
            win2_next = new_col;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= WW'(W_RST);
            h_reg         <= HW'(H_RST);
            row_reg       <= '0;
            col_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            win0_reg      <= '0;
            win1_reg      <= '0;
            win2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            w_reg         <= w_next;
            h_reg         <= h_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            s1_valid_reg  <= s1_valid_next;
            win0_reg      <= win0_next;
            win1_reg      <= win1_next;
            win2_reg      <= win2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bottom_reg   <= bottom0;
            s1_top_ok_reg   <= top_ok0;
            s1_mid_ok_reg   <= mid_ok0;
            s1_emit_reg     <= emit0;
            s1_last_reg     <= last0;
            s1_left_ok_reg  <= (col_reg != CW'(1));
            s1_right_ok_reg <= (col_reg != '0);
            s1_addr_reg     <= col_reg;
            s1_row_reg      <= orow0[COORD_W-1:0];
            s1_col_reg      <= ocol0[COORD_W-1:0];
        end
        if (out_load)
        begin
            out_alive_reg <= alive1;
            out_last_reg  <= s1_last_reg;
            out_row_reg   <= s1_row_reg;
            out_col_reg   <= s1_col_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign next_alive = out_alive_reg;
    assign cell_row   = out_row_reg;
    assign cell_col   = out_col_reg;
    assign last_cell  = out_last_reg;

endmodule

// File: rtl/lgs_checker.sv
module lgs_checker
    import lgs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               next_alive,
    input logic [COORD_W-1:0] cell_row,
    input logic [COORD_W-1:0] cell_col,
    input logic               last_cell
);

    // stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(next_alive) && $stable(cell_row)
            && $stable(cell_col) && $stable(last_cell))
        else $error("output payload changed while stalled");

    // input backpressure only comes from a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a new generation needs a full row before its first result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_cell |=> !out_valid)
        else $error("result right after end of generation");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (.*);

// File: tb/tb_life_generation_stencil.sv
module tb_life_generation_stencil;
    import lgs_pkg::*;

    localparam int MAX_DIM      = 256;
    localparam int RANDOM_BEATS = 400;
    localparam int WIDE_BEATS   = 520;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic               alive;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } cell_result_t;

    // Next-generation predictor: line stores, 3x3 window and raster position.
    class life_board;
        bit [CFG_DATA_W-1:0] width_reg;
        bit [CFG_DATA_W-1:0] height_reg;
        bit                  above_line [MAX_DIM];
        bit                  cur_line [MAX_DIM];
        bit                  win [3][3];
        int unsigned         row_in;
        int unsigned         col_in;
        int unsigned         out_pos;
        cell_result_t        next_cells [$];
        int                  errors;

        function new();
            width_reg  = CFG_DATA_W'(GRID_RESET);
            height_reg = CFG_DATA_W'(GRID_RESET);
            errors     = 0;
            restart();
        endfunction

        function void restart();
            foreach (win[i, j])
                win[i][j] = 1'b0;
            row_in  = 0;
            col_in  = 0;
            out_pos = 0;
        endfunction

        function int unsigned dim_used(bit [CFG_DATA_W-1:0] v);
            if (v < DIM_MIN)
                return DIM_MIN;
            if (v > MAX_DIM)
                return MAX_DIM;
            return v;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_GRID_WIDTH)
                width_reg = data;
            else
                height_reg = data;
            restart();
        endfunction

        // B3/S23 on window column mid; outer columns only where inside the grid
        function bit cell_next(int mid, bit left_ok, bit right_ok);
            int n;
            n = 0;
            for (int k = 0; k < 3; k++)
            begin
                if (left_ok)
                    n += win[k][mid-1];
                if (right_ok)
                    n += win[k][mid+1];
                if (k != 1)
                    n += win[k][mid];
            end
            if (win[1][mid])
                return (n == 2) || (n == 3);
            return n == 3;
        endfunction

        function void take_cell(bit alive, bit fl);
            int unsigned  w;
            int unsigned  h;
            int unsigned  r;
            int unsigned  c;
            int unsigned  orow;
            int unsigned  ocol;
            bit           bottom;
            bit           top;
            bit           mid;
            bit           emit;
            bit           nxt;
            cell_result_t e;
            w      = dim_used(width_reg);
            h      = dim_used(height_reg);
            r      = row_in;
            c      = col_in;
            bottom = (!fl && r < h) ? alive : 1'b0;
            emit   = (r >= 2) || (r == 1 && c >= 1);
            top    = 1'b0;
            mid    = 1'b0;
            nxt    = 1'b0;
            if (c >= w)
                c = 0;
            if (r >= 2 && r - 2 < h)
                top = above_line[c];
            if (r >= 1 && r - 1 < h)
                mid = cur_line[c];
            // column 0 closes the last column of the previous row
            if (emit && c == 0)
                nxt = cell_next(2, 1'b1, 1'b0);
            above_line[c] = mid;
            cur_line[c]   = bottom;
            for (int k = 0; k < 3; k++)
            begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = bottom;
            if (emit && c != 0)
                nxt = cell_next(1, c != 1, 1'b1);
            if (c == 0)
            begin
                orow = r - 2;
                ocol = w - 1;
            end
            else
            begin
                orow = r - 1;
                ocol = c - 1;
            end
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
            end
            row_in = r & 9'h1FF;
            col_in = c;
            if (!emit)
                return;
            e.alive = nxt;
            e.row   = orow[COORD_W-1:0];
            e.col   = ocol[COORD_W-1:0];
            e.last  = (out_pos == w * h - 1);
            next_cells.push_back(e);
            if (e.last)
                restart();
            else
                out_pos = (out_pos + 1) & 17'h1FFFF;
        endfunction

        function void check_cell(logic a, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                                 logic l);
            cell_result_t e;
            if (next_cells.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: alive=%0d row=%0d col=%0d last=%0d",
                             a, r, c, l);
                return;
            end
            e = next_cells.pop_front();
            if (e.alive !== a || e.row !== r || e.col !== c || e.last !== l)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %0d (%0d,%0d) last %0d, got %0d (%0d,%0d) last %0d",
                             e.alive, e.row, e.col, e.last, a, r, c, l);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  cell_alive;
    logic                  flush;
    logic                  out_valid;
    logic                  out_stall;
    logic                  next_alive;
    logic [COORD_W-1:0]    cell_row;
    logic [COORD_W-1:0]    cell_col;
    logic                  last_cell;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    life_board board;
    int        send_idle;
    int        recv_stall;
    int        beats_in;

    life_generation_stencil u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_alive (cell_alive),
        .flush      (flush),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .next_alive (next_alive),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .last_cell  (last_cell),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_life_generation_stencil: errors");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_cell(next_alive, cell_row, cell_col, last_cell);
    end

    task automatic send_beat(input logic alive, input logic fl);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        cell_alive <= alive;
        flush      <= fl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.take_cell(alive, fl);
        beats_in++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (board.next_cells.size() != 0);
    endtask

    task automatic quiesce();
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // one generation: cells, then width+1 drain beats; cut_short stops mid-frame
    task automatic run_generation(input int density, input bit cut_short);
        int w;
        int total;
        int stop_at;
        w       = board.dim_used(board.width_reg);
        total   = w * board.dim_used(board.height_reg);
        stop_at = cut_short ? $urandom_range(1, total - 1) : total;
        for (int n = 0; n < stop_at; n++)
        begin
            if (n == total / 2 && $urandom_range(7) == 0)
                wait_drained();
            send_beat($urandom_range(99) < density, $urandom_range(49) == 0);
        end
        if (!cut_short)
        begin
            for (int n = 0; n <= w; n++)
                send_beat(1'($urandom_range(1)), $urandom_range(3) != 0);
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dim(input int big_max);
        case ($urandom_range(19))
            0:       return CFG_DATA_W'($urandom_range(0, DIM_MIN - 1));
            1, 2:    return CFG_DATA_W'($urandom_range(13, big_max));
            default: return CFG_DATA_W'($urandom_range(DIM_MIN, 12));
        endcase
    endfunction

    initial
    begin
        bit [8:0] blinker;
        int       target;
        int       k;
        bit       cut;
        board      = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cell_alive = 1'b0;
        flush      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_GRID_WIDTH;
        cfg_data   = '0;
        send_idle  = 0;
        recv_stall = 0;
        beats_in   = 0;
        blinker    = 9'b000_111_000;
        cut        = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset dimensions, partial frame, then restart by a register write
        repeat (205)
            send_beat(1'($urandom_range(1)), 1'b0);
        quiesce();

        // 3x3 via clamp from below: blinker, then drain with non-flush beat
        write_reg(REG_GRID_WIDTH, 9'd2);
        write_reg(REG_GRID_HEIGHT, 9'd1);
        for (int i = 0; i < 9; i++)
            send_beat(blinker[i], 1'b0);
        send_beat(1'b1, 1'b0);
        send_beat(1'b1, 1'b1);
        send_beat(1'b0, 1'b1);
        send_beat(1'b0, 1'b1);
        // all live, flush in the center before frame end, sender holds mid-frame
        for (int i = 0; i < 9; i++)
        begin
            if (i == 5)
                wait_drained();
            send_beat(1'b1, i == 4);
        end
        repeat (4)
            send_beat(1'b0, 1'b1);
        quiesce();

        // both dimensions clamped from above; run past the last column of row 0
        send_idle  = 24;
        recv_stall = 24;
        write_reg(REG_GRID_WIDTH, 9'h1FF);
        write_reg(REG_GRID_HEIGHT, 9'h1FF);
        repeat (WIDE_BEATS)
            send_beat(1'($urandom_range(99) < 40), 1'b0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 55;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 55;
                end
                default:
                begin
                    send_idle  = 24;
                    recv_stall = 24;
                end
            endcase
            target = beats_in + RANDOM_BEATS / 4;
            while (beats_in < target)
            begin
                if (cut || (phase == 0 && beats_in < target - RANDOM_BEATS / 4 + 1)
                    || $urandom_range(9) < 6)
                begin
                    quiesce();
                    k = $urandom_range(2);
                    if (k != 1)
                        write_reg(REG_GRID_WIDTH, pick_dim(40));
                    if (k != 0)
                        write_reg(REG_GRID_HEIGHT, pick_dim(20));
                end
                cut = ($urandom_range(11) == 0);
                run_generation($urandom_range(5, 70), cut);
            end
        end

        wait_drained();
        repeat (40) @(negedge clk);
        if (board.errors == 0)
            $display("tb_life_generation_stencil: clean");
        else
            $display("tb_life_generation_stencil: errors");
        $finish;
    end

endmodule

// File: life_generation_stencil.f
rtl/lgs_pkg.sv
rtl/lgs_line_store.sv
rtl/life_generation_stencil.sv
rtl/lgs_checker.sv
tb/tb_life_generation_stencil.sv
